>>> hdl/ldm_pkg.sv
`timescale 1ns / 1ps
package ldm_pkg;

  localparam int ImageWidth  = 1024;
  localparam int ImageHeight = 768;
  localparam int MaxPasses   = 100;

  localparam int CoordW = 18;
  localparam int NormW  = 23;
  localparam int NumW   = 44;
  localparam int DenW   = 20;
  localparam int DivSteps = 23;
  localparam int OpaW   = 48;
  localparam int OpbW   = 27;
  localparam int ProdW  = OpaW + OpbW;
  localparam int ErrW   = 40;

  localparam logic [ErrW-1:0] ErrEps = ErrW'(64);

  localparam logic [2:0] RegFocalX = 3'd0;
  localparam logic [2:0] RegFocalY = 3'd1;
  localparam logic [2:0] RegPp     = 3'd2;
  localparam logic [2:0] RegK1     = 3'd3;
  localparam logic [2:0] RegK2     = 3'd4;
  localparam logic [2:0] RegK3     = 3'd5;
  localparam logic [2:0] RegP1     = 3'd6;
  localparam logic [2:0] RegP2     = 3'd7;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [NormW-1:0] quot;
  } div_rsp_t;

  // round to nearest, ties away from zero
  function automatic logic signed [ProdW-1:0] rshr(input logic signed [ProdW-1:0] p,
                                                   input logic [4:0] sh);
    logic [ProdW-1:0] mag;
    logic [ProdW-1:0] r;
    mag = p[ProdW-1] ? ProdW'(-p) : ProdW'(p);
    r = (mag + (ProdW'(1) << (sh - 5'd1))) >> sh;
    return p[ProdW-1] ? $signed(-r) : $signed(r);
  endfunction

  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [ProdW-1:0] v);
    if (v < -$signed(ProdW'(131072))) return CoordW'(-131072);
    if (v > $signed(ProdW'(131071))) return CoordW'(131071);
    return CoordW'(v);
  endfunction

endpackage

>>> hdl/ldm_if.sv
`timescale 1ns / 1ps
interface ldm_in_if;
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic signed [ldm_pkg::CoordW-1:0] coord_x;
  logic signed [ldm_pkg::CoordW-1:0] coord_y;
  modport source (output valid, req_type, coord_x, coord_y, input ready);
  modport sink (input valid, req_type, coord_x, coord_y, output ready);
endinterface

interface ldm_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [ldm_pkg::CoordW-1:0] out_x;
  logic signed [ldm_pkg::CoordW-1:0] out_y;
  logic                            converged;
  modport source (output valid, out_x, out_y, converged, input ready);
  modport sink (input valid, out_x, out_y, converged, output ready);
endinterface

>>> hdl/ldm_div.sv
`timescale 1ns / 1ps
module ldm_div (
  input  logic              clk,
  input  logic              rst,
  input  ldm_pkg::div_req_t req,
  output ldm_pkg::div_rsp_t rsp
);
  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t state;
  logic [ldm_pkg::DenW-1:0]  rem;
  logic [ldm_pkg::NormW-1:0] low;
  logic [ldm_pkg::NormW-1:0] quot;
  logic [4:0]                cnt;
  logic                      done;
  logic                      ovf;
  logic [ldm_pkg::DenW:0]    trial;

  assign trial = {rem, low[ldm_pkg::NormW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            // quotient too large for the normalized range: report saturation
            if (req.num[ldm_pkg::NumW-1:ldm_pkg::NormW] >= {1'b0, req.den}) begin
              ovf  <= 1'b1;
              done <= 1'b1;
            end else begin
              ovf   <= 1'b0;
              rem   <= req.num[ldm_pkg::NumW-2:ldm_pkg::NormW];
              low   <= req.num[ldm_pkg::NormW-1:0];
              quot  <= '0;
              cnt   <= 5'(ldm_pkg::DivSteps);
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (trial >= {1'b0, req.den}) begin
            rem  <= ldm_pkg::DenW'(trial - {1'b0, req.den});
            quot <= {quot[ldm_pkg::NormW-2:0], 1'b1};
          end else begin
            rem  <= trial[ldm_pkg::DenW-1:0];
            quot <= {quot[ldm_pkg::NormW-2:0], 1'b0};
          end
          low <= {low[ldm_pkg::NormW-2:0], 1'b0};
          cnt <= cnt - 5'd1;
          if (cnt == 5'd1) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.ovf  = ovf;
  assign rsp.quot = quot;
endmodule

>>> hdl/lens_distortion_mapper_top.sv
`timescale 1ns / 1ps
// Brown-Conrady lens distortion mapper.
// Configure focal lengths, principal point and coefficients through the
// write port (wr_en, wr_index, wr_data) while no item is in flight.
// The in_ch channel takes one item: req_type (0 distort, 1 undistort) and a
// Q13.4 coordinate pair. Each item gives exactly one result on out_ch:
// mapped coordinate and a converged flag (always 1 for distort).
// One item at a time: in_ch.ready is high only while the sequencer is idle.
// Each division runs on the shared divider: a start, 23 steps and the done
// handoff. Each multiply runs on the shared 25x27 multiplier: low half,
// high half, then round and accumulate.
// Distort runs two divisions and 16 multiplies. Undistort repeats the
// evaluation plus two error squares in each pass, up to MAX_PASSES passes.
// The result sits in an output register; if the receiver stalls, the block
// holds it and finishes the next item only up to the delivery step.
// Synchronous reset returns the registers to an identity camera and empties
// the output.
module lens_distortion_mapper_top #(
  parameter int IMAGE_WIDTH  = ldm_pkg::ImageWidth,
  parameter int IMAGE_HEIGHT = ldm_pkg::ImageHeight,
  parameter int MAX_PASSES   = ldm_pkg::MaxPasses
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  ldm_in_if.sink      in_ch,
  ldm_out_if.source   out_ch
);
  localparam int CW = ldm_pkg::CoordW;
  localparam int PW = ldm_pkg::ProdW;
  localparam int PassW = $clog2(MAX_PASSES + 1);
  localparam logic signed [CW-1:0] XMax = CW'((IMAGE_WIDTH - 1) * 16);
  localparam logic signed [CW-1:0] YMax = CW'((IMAGE_HEIGHT - 1) * 16);
  localparam logic [PassW-1:0] PassLast = PassW'(MAX_PASSES);

  typedef enum logic [3:0] {
    S_IDLE, S_DIVX_GO, S_DIVX_WAIT, S_DIVY_GO, S_DIVY_WAIT, S_MUL_LO, S_MUL_HI, S_ACC,
    S_DELIVER
  } state_t;

  typedef enum logic [4:0] {
    OP_X2, OP_Y2, OP_TXY, OP_R4, OP_R6, OP_T1, OP_T2, OP_T3,
    OP_XD1, OP_XD2, OP_XD3, OP_YD1, OP_YD2, OP_YD3, OP_OU, OP_OV, OP_EX, OP_EY
  } op_t;

  // configuration
  logic [19:0]        focal_x, focal_y;
  logic [31:0]        principal_point;
  logic signed [23:0] radial_k1, radial_k2, radial_k3, tangential_p1, tangential_p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x         <= 20'd256;
      focal_y         <= 20'd256;
      principal_point <= '0;
      radial_k1       <= '0;
      radial_k2       <= '0;
      radial_k3       <= '0;
      tangential_p1   <= '0;
      tangential_p2   <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        ldm_pkg::RegFocalX: focal_x         <= wr_data[19:0];
        ldm_pkg::RegFocalY: focal_y         <= wr_data[19:0];
        ldm_pkg::RegPp:     principal_point <= wr_data;
        ldm_pkg::RegK1:     radial_k1       <= wr_data[23:0];
        ldm_pkg::RegK2:     radial_k2       <= wr_data[23:0];
        ldm_pkg::RegK3:     radial_k3       <= wr_data[23:0];
        ldm_pkg::RegP1:     tangential_p1   <= wr_data[23:0];
        ldm_pkg::RegP2:     tangential_p2   <= wr_data[23:0];
        default: ;
      endcase
    end
  end

  logic [19:0] fxe, fye;
  logic [15:0] cx, cy;
  assign fxe = (focal_x == '0) ? 20'd1 : focal_x;
  assign fye = (focal_y == '0) ? 20'd1 : focal_y;
  assign cx  = principal_point[15:0];
  assign cy  = principal_point[31:16];

  // datapath state
  state_t state;
  op_t    op;
  logic   mode;
  logic signed [CW-1:0] tx, ty, rx, ry, ou, ov;
  logic signed [22:0]   x, y;
  logic signed [26:0]   x2, y2, r2, txy;
  logic signed [31:0]   r4;
  logic signed [36:0]   r6;
  logic signed [47:0]   t, xd, yd;
  logic [ldm_pkg::ErrW-1:0] err;
  logic [PassW-1:0]     pass;
  logic                 div_neg;
  logic signed [PW-1:0] prod;

  logic signed [CW-1:0] res_x, res_y;
  logic                 res_c;
  logic                 out_valid;
  logic signed [CW-1:0] out_x_r, out_y_r;
  logic                 out_c_r;

  // divider
  ldm_pkg::div_req_t div_req;
  ldm_pkg::div_rsp_t div_rsp;
  logic signed [18:0] diff;
  logic [18:0]        diff_mag;
  logic [19:0]        den;

  always_comb begin
    if (state == S_DIVY_GO || state == S_DIVY_WAIT) begin
      diff = $signed({ry[CW-1], ry}) - $signed({3'd0, cy});
      den  = fye;
    end else begin
      diff = $signed({rx[CW-1], rx}) - $signed({3'd0, cx});
      den  = fxe;
    end
    diff_mag      = diff[18] ? 19'(-diff) : 19'(diff);
    div_req.start = (state == S_DIVX_GO) || (state == S_DIVY_GO);
    div_req.num   = ({25'd0, diff_mag} << 24) + ldm_pkg::NumW'(den >> 1);
    div_req.den   = den;
  end

  ldm_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // saturate the rounded quotient to [-4, 4)
  logic signed [22:0] norm;
  always_comb begin
    if (div_rsp.ovf) begin
      norm = div_neg ? -23'sd4194304 : 23'sd4194303;
    end else if (div_neg) begin
      norm = (div_rsp.quot > 23'd4194304) ? -23'sd4194304 : 23'(-div_rsp.quot);
    end else begin
      norm = (div_rsp.quot > 23'd4194303) ? 23'sd4194303 : 23'(div_rsp.quot);
    end
  end

  // shared multiplier operands
  logic signed [18:0] dx, dy;
  logic signed [47:0] a_op;
  logic signed [26:0] b_op;
  logic signed [47:0] tanx, tany;
  assign dx   = $signed({tx[CW-1], tx}) - $signed({ou[CW-1], ou});
  assign dy   = $signed({ty[CW-1], ty}) - $signed({ov[CW-1], ov});
  assign tanx = 48'(r2) + (48'(x2) <<< 1);
  assign tany = 48'(r2) + (48'(y2) <<< 1);

  always_comb begin
    unique case (op)
      OP_X2:  begin a_op = 48'(x);    b_op = 27'(x);             end
      OP_Y2:  begin a_op = 48'(y);    b_op = 27'(y);             end
      OP_TXY: begin a_op = 48'(x);    b_op = 27'(y);             end
      OP_R4:  begin a_op = 48'(r2);   b_op = r2;                 end
      OP_R6:  begin a_op = 48'(r4);   b_op = r2;                 end
      OP_T1:  begin a_op = 48'(r2);   b_op = 27'(radial_k1);     end
      OP_T2:  begin a_op = 48'(r4);   b_op = 27'(radial_k2);     end
      OP_T3:  begin a_op = 48'(r6);   b_op = 27'(radial_k3);     end
      OP_XD1: begin a_op = t;         b_op = 27'(x);             end
      OP_XD2: begin a_op = 48'(txy);  b_op = 27'(tangential_p1); end
      OP_XD3: begin a_op = tanx;      b_op = 27'(tangential_p2); end
      OP_YD1: begin a_op = t;         b_op = 27'(y);             end
      OP_YD2: begin a_op = 48'(txy);  b_op = 27'(tangential_p2); end
      OP_YD3: begin a_op = tany;      b_op = 27'(tangential_p1); end
      OP_OU:  begin a_op = xd;        b_op = $signed({7'd0, fxe}); end
      OP_OV:  begin a_op = yd;        b_op = $signed({7'd0, fye}); end
      OP_EX:  begin a_op = 48'(dx);   b_op = 27'(dx);            end
      OP_EY:  begin a_op = 48'(dy);   b_op = 27'(dy);            end
      default: begin a_op = '0;       b_op = '0;                 end
    endcase
  end

  // one 25x27 multiplier: the wide operand goes through as low half, then high half
  logic signed [24:0] m_a;
  logic signed [51:0] m_p;
  assign m_a = (state == S_MUL_HI) ? $signed({a_op[47], a_op[47:24]})
                                   : $signed({1'b0, a_op[23:0]});
  assign m_p = m_a * b_op;

  // rounding and end-of-pass logic
  logic [4:0]           sh;
  logic signed [PW-1:0] rs;
  logic signed [CW-1:0] map_sat;
  logic [ldm_pkg::ErrW-1:0] err_n;
  logic signed [19:0]   sx, sy;
  logic signed [CW-1:0] rx_n, ry_n, cl_x, cl_y;
  logic [PassW-1:0]     pass_n;

  always_comb begin
    if (op == OP_TXY) sh = 5'd19;
    else if (op == OP_OU || op == OP_OV) sh = 5'd24;
    else sh = 5'd20;
    rs = ldm_pkg::rshr(prod, sh);
    if (op == OP_OU) map_sat = ldm_pkg::sat_coord(rs + $signed({59'd0, cx}));
    else map_sat = ldm_pkg::sat_coord(rs + $signed({59'd0, cy}));
    err_n  = err + ldm_pkg::ErrW'(prod);
    pass_n = pass + PassW'(1);
    sx = $signed({{2{rx[CW-1]}}, rx}) + $signed({dx[18], dx});
    sy = $signed({{2{ry[CW-1]}}, ry}) + $signed({dy[18], dy});
    rx_n = ldm_pkg::sat_coord(PW'(sx));
    ry_n = ldm_pkg::sat_coord(PW'(sy));
    cl_x = (rx_n < 0) ? '0 : ((rx_n > XMax) ? XMax : rx_n);
    cl_y = (ry_n < 0) ? '0 : ((ry_n > YMax) ? YMax : ry_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_X2;
      pass      <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop the taken result unless a new one is loaded this cycle
      if (out_valid && out_ch.ready && state != S_DELIVER) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            mode  <= in_ch.req_type;
            tx    <= in_ch.coord_x;
            ty    <= in_ch.coord_y;
            rx    <= in_ch.coord_x;
            ry    <= in_ch.coord_y;
            pass  <= '0;
            err   <= '0;
            state <= S_DIVX_GO;
          end
        end
        S_DIVX_GO: begin
          div_neg <= diff[18];
          state   <= S_DIVX_WAIT;
        end
        S_DIVX_WAIT: begin
          if (div_rsp.done) begin
            x     <= norm;
            state <= S_DIVY_GO;
          end
        end
        S_DIVY_GO: begin
          div_neg <= diff[18];
          state   <= S_DIVY_WAIT;
        end
        S_DIVY_WAIT: begin
          if (div_rsp.done) begin
            y     <= norm;
            op    <= OP_X2;
            state <= S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          prod  <= PW'(m_p);
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          prod  <= prod + (PW'(m_p) <<< 24);
          state <= S_ACC;
        end
        S_ACC: begin
          state <= S_MUL_LO;
          op    <= op_t'(5'(op) + 5'd1);
          unique case (op)
            OP_X2:  x2  <= 27'(rs);
            OP_Y2:  begin y2 <= 27'(rs); r2 <= x2 + 27'(rs); end
            OP_TXY: txy <= 27'(rs);
            OP_R4:  r4  <= 32'(rs);
            OP_R6:  r6  <= 37'(rs);
            OP_T1:  t   <= 48'sd1048576 + 48'(rs);
            OP_T2, OP_T3: t <= t + 48'(rs);
            OP_XD1: xd  <= 48'(rs);
            OP_XD2, OP_XD3: xd <= xd + 48'(rs);
            OP_YD1: yd  <= 48'(rs);
            OP_YD2, OP_YD3: yd <= yd + 48'(rs);
            OP_OU:  ou  <= map_sat;
            OP_OV: begin
              ov <= map_sat;
              if (!mode) begin
                res_x <= ou;
                res_y <= map_sat;
                res_c <= 1'b1;
                state <= S_DELIVER;
              end
            end
            OP_EX:  err <= ldm_pkg::ErrW'(prod);
            OP_EY: begin
              rx   <= rx_n;
              ry   <= ry_n;
              pass <= pass_n;
              err  <= err_n;
              if (pass_n == PassLast || err_n <= ldm_pkg::ErrEps) begin
                res_x <= cl_x;
                res_y <= cl_y;
                res_c <= (err_n <= ldm_pkg::ErrEps);
                state <= S_DELIVER;
              end else begin
                state <= S_DIVX_GO;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_DELIVER: begin
          // hold until the output register is free
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_x_r   <= res_x;
            out_y_r   <= res_y;
            out_c_r   <= res_c;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready      = (state == S_IDLE);
  assign out_ch.valid     = out_valid;
  assign out_ch.out_x     = out_x_r;
  assign out_ch.out_y     = out_y_r;
  assign out_ch.converged = out_c_r;

`ifndef SYNTHESIS
  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    pass <= PassLast) else $error("pass count beyond limit");
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIVX_WAIT || state == S_DIVY_WAIT))
    else $error("divider done outside a wait state");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("ready stayed high after accepting an item");
  a_unconv_clamped: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.converged) |->
      (out_ch.out_x >= 0 && out_ch.out_x <= XMax &&
       out_ch.out_y >= 0 && out_ch.out_y <= YMax))
    else $error("unconverged result outside the image");
`endif
endmodule

>>> tb/ldm_tb_if.sv
`timescale 1ns / 1ps
// The channels come from hdl/ldm_if.sv; this file holds the shared
// constants of the test (register codes are taken from ldm_pkg).
package ldm_tb_pkg;
  localparam logic ReqDistort   = 1'b0;
  localparam logic ReqUndistort = 1'b1;
endpackage

>>> tb/ldm_checker.sv
`timescale 1ns / 1ps
module ldm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  ldm_in_if           in_ch,
  ldm_out_if          out_ch,
  output int          fail_count,
  output int          pending
);
  typedef struct {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic               conv;
  } mapped_t;

  longint fx, fy, cx, cy, k1, k2, k3, p1, p2;
  mapped_t mapped_q[$];

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint round_shift(longint p, int sh);
    longint half;
    half = longint'(1) << (sh - 1);
    if (p >= 0) return (p + half) >>> sh;
    return -((-p + half) >>> sh);
  endfunction

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic void warp(input longint u, input longint v, output longint ou,
                               output longint ov);
    longint gx, gy, x, y, x2, y2, txy, r2, r4, r6, t, xd, yd;
    gx = (fx == 0) ? 1 : fx;
    gy = (fy == 0) ? 1 : fy;
    x = clip(round_div((u - cx) * 16777216, gx), -4194304, 4194303);
    y = clip(round_div((v - cy) * 16777216, gy), -4194304, 4194303);
    x2 = round_shift(x * x, 20);
    y2 = round_shift(y * y, 20);
    txy = round_shift(2 * x * y, 20);
    r2 = x2 + y2;
    r4 = round_shift(r2 * r2, 20);
    r6 = round_shift(r4 * r2, 20);
    t = 1048576 + round_shift(k1 * r2, 20) + round_shift(k2 * r4, 20)
        + round_shift(k3 * r6, 20);
    xd = round_shift(x * t, 20) + round_shift(txy * p1, 20)
         + round_shift(p2 * (r2 + 2 * x2), 20);
    yd = round_shift(y * t, 20) + round_shift(txy * p2, 20)
         + round_shift(p1 * (r2 + 2 * y2), 20);
    ou = clip(round_shift(xd * gx, 24) + cx, -131072, 131071);
    ov = clip(round_shift(yd * gy, 24) + cy, -131072, 131071);
  endfunction

  function automatic mapped_t map_point(logic req, longint tx, longint ty);
    mapped_t m;
    longint rx, ry, cu, cv, dx, dy;
    longint unsigned err;
    err = '1;
    m.conv = 1'b1;
    if (req == ldm_tb_pkg::ReqDistort) begin
      warp(tx, ty, rx, ry);
    end else begin
      rx = tx;
      ry = ty;
      for (int n = 0; n < ldm_pkg::MaxPasses && err > 64; n++) begin
        warp(rx, ry, cu, cv);
        dx = tx - cu;
        dy = ty - cv;
        rx = clip(rx + dx, -131072, 131071);
        ry = clip(ry + dy, -131072, 131071);
        err = longint'(dx * dx) + longint'(dy * dy);
      end
      rx = clip(rx, 0, (ldm_pkg::ImageWidth - 1) * 16);
      ry = clip(ry, 0, (ldm_pkg::ImageHeight - 1) * 16);
      m.conv = err <= 64;
    end
    m.x = rx[17:0];
    m.y = ry[17:0];
    return m;
  endfunction

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    mapped_t m;
    if (rst) begin
      fx = 256; fy = 256; cx = 0; cy = 0;
      k1 = 0; k2 = 0; k3 = 0; p1 = 0; p2 = 0;
      fail_count = 0;
      mapped_q.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          ldm_pkg::RegFocalX: fx = wr_data[19:0];
          ldm_pkg::RegFocalY: fy = wr_data[19:0];
          ldm_pkg::RegPp: begin
            cx = wr_data[15:0];
            cy = wr_data[31:16];
          end
          ldm_pkg::RegK1: k1 = $signed(wr_data[23:0]);
          ldm_pkg::RegK2: k2 = $signed(wr_data[23:0]);
          ldm_pkg::RegK3: k3 = $signed(wr_data[23:0]);
          ldm_pkg::RegP1: p1 = $signed(wr_data[23:0]);
          ldm_pkg::RegP2: p2 = $signed(wr_data[23:0]);
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (mapped_q.size() == 0) begin
          report("result with no item pending");
        end else begin
          m = mapped_q.pop_front();
          if (out_ch.out_x !== m.x)
            report($sformatf("out_x %0d want %0d", out_ch.out_x, m.x));
          if (out_ch.out_y !== m.y)
            report($sformatf("out_y %0d want %0d", out_ch.out_y, m.y));
          if (out_ch.converged !== m.conv)
            report($sformatf("converged %0b want %0b", out_ch.converged, m.conv));
        end
      end
      if (in_ch.valid && in_ch.ready)
        mapped_q.push_back(map_point(in_ch.req_type, in_ch.coord_x, in_ch.coord_y));
    end
    pending = mapped_q.size();
  end
endmodule

>>> tb/lens_distortion_mapper_top_test.sv
`timescale 1ns / 1ps
module lens_distortion_mapper_top_test;
  localparam longint CycleLimit = 64'd100_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [31:0] wr_data = '0;
  int fail_count;
  int pending;
  longint cycles = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;

  ldm_in_if in_ch ();
  ldm_out_if out_ch ();

  lens_distortion_mapper_top u_dut (
    .clk, .rst, .wr_en, .wr_index, .wr_data, .in_ch, .out_ch
  );

  ldm_checker u_checker (
    .clk, .rst, .wr_en, .wr_index, .wr_data, .in_ch, .out_ch,
    .fail_count, .pending
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = 1'b0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (rst || hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm || ($urandom_range(99) >= 31);
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // valid stays up after an accept; the next call idles it or offers a new item
  task automatic send_item(input logic req, input logic [17:0] x, input logic [17:0] y);
    while (!calm && $urandom_range(99) < 31) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.coord_x <= x;
    in_ch.coord_y <= y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coef(int span);
    int v;
    v = $urandom_range(2 * span) - span;
    return 32'(v);
  endfunction

  // mostly pixels inside the image, sometimes anything at all
  function automatic logic [17:0] rand_coord(int lim);
    if ($urandom_range(9) < 8) return 18'($urandom_range(lim * 16));
    return 18'($urandom);
  endfunction

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++)
      send_item(1'($urandom), rand_coord(ldm_pkg::ImageWidth - 1),
                rand_coord(ldm_pkg::ImageHeight - 1));
  endtask

  initial begin
    logic [17:0] edge_vals[4];
    edge_vals = '{18'h20000, 18'h1ffff, 18'h0, 18'h3ffff};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity camera at reset
    foreach (edge_vals[i]) begin
      send_item(ldm_tb_pkg::ReqDistort, edge_vals[i], edge_vals[3 - i]);
      send_item(ldm_tb_pkg::ReqUndistort, edge_vals[i], edge_vals[i]);
    end
    drain();

    // typical camera
    write_reg(ldm_pkg::RegFocalX, 32'd800 << 8);
    write_reg(ldm_pkg::RegFocalY, 32'd780 << 8);
    write_reg(ldm_pkg::RegPp, {16'(384 * 16), 16'(512 * 16)});
    write_reg(ldm_pkg::RegK1, rand_coef(200000));
    write_reg(ldm_pkg::RegK2, rand_coef(50000));
    write_reg(ldm_pkg::RegK3, rand_coef(10000));
    write_reg(ldm_pkg::RegP1, rand_coef(3000));
    write_reg(ldm_pkg::RegP2, rand_coef(3000));
    foreach (edge_vals[i]) begin
      send_item(ldm_tb_pkg::ReqDistort, edge_vals[i], edge_vals[i]);
      send_item(ldm_tb_pkg::ReqUndistort, edge_vals[3 - i], edge_vals[i]);
    end
    send_item(ldm_tb_pkg::ReqUndistort, 18'(512 * 16), 18'(384 * 16));
    drain();

    // zero focal lengths, upper bits of the data word ignored
    write_reg(ldm_pkg::RegFocalX, 32'h0);
    write_reg(ldm_pkg::RegFocalY, 32'hfff00000);
    send_item(ldm_tb_pkg::ReqDistort, 18'd5, 18'h3fffb);
    send_item(ldm_tb_pkg::ReqUndistort, 18'd100, 18'd100);
    drain();

    // extreme registers
    write_reg(ldm_pkg::RegFocalX, 32'hfffff);
    write_reg(ldm_pkg::RegFocalY, 32'hfffff);
    write_reg(ldm_pkg::RegPp, 32'hffffffff);
    write_reg(ldm_pkg::RegK1, 32'h7fffff);
    write_reg(ldm_pkg::RegK2, 32'h800000);
    write_reg(ldm_pkg::RegK3, 32'h7fffff);
    write_reg(ldm_pkg::RegP1, 32'h800000);
    write_reg(ldm_pkg::RegP2, 32'h7fffff);
    send_item(ldm_tb_pkg::ReqDistort, 18'h1ffff, 18'h20000);
    send_item(ldm_tb_pkg::ReqUndistort, 18'h0, 18'h1ffff);
    drain();

    // random settings; first phase runs without idling, and one phase
    // backs up behind a long receiver hold-off
    for (int ph = 0; ph < 10; ph++) begin
      calm = (ph == 0);
      write_reg(ldm_pkg::RegFocalX, 32'($urandom_range(20'hfffff, 256)));
      write_reg(ldm_pkg::RegFocalY, 32'($urandom_range(20'hfffff, 256)));
      write_reg(ldm_pkg::RegPp, {16'($urandom_range(ldm_pkg::ImageHeight * 16)),
                                 16'($urandom_range(ldm_pkg::ImageWidth * 16))});
      write_reg(ldm_pkg::RegK1, ph < 6 ? rand_coef(300000) : 32'($urandom));
      write_reg(ldm_pkg::RegK2, ph < 6 ? rand_coef(80000) : 32'($urandom));
      write_reg(ldm_pkg::RegK3, ph < 6 ? rand_coef(20000) : 32'($urandom));
      write_reg(ldm_pkg::RegP1, ph < 6 ? rand_coef(5000) : 32'($urandom));
      write_reg(ldm_pkg::RegP2, ph < 6 ? rand_coef(5000) : 32'($urandom));
      if (ph == 3) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (3000) @(posedge clk);
            hold_off = 1'b0;
          end
          random_phase(150);
        join
      end else begin
        random_phase(150);
      end
      drain();
    end
    calm = 1'b0;

    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
